// ===== hw/rtl/tgp_pkg.sv =====
// Package for the turtle grid plotter: command codes and result field widths.
// No dependencies; used by turtle_grid_plotter.
package tgp_pkg;

  typedef enum logic [3:0] {
    CMD_PEN_UP   = 4'd1,
    CMD_PEN_DOWN = 4'd2,
    CMD_RIGHT    = 4'd3,
    CMD_LEFT     = 4'd4,
    CMD_MOVE     = 4'd5,
    CMD_PRINT    = 4'd6,
    CMD_EXIT     = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  localparam int unsigned CMD_W      = 4;
  localparam int unsigned DIST_W     = 6;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned BITS_W     = 32;
  localparam int unsigned MAX_ROWS   = 32;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

endpackage

// ===== hw/rtl/turtle_grid_plotter.sv =====
// Turtle grid plotter top level: command decoder, turtle walk sequencer, bitmap RAM.
// Depends on tgp_pkg and tgp_ram.
//
// The block takes one command item at a time and answers each known command code
// with one status item, or for print with one row item per bitmap row (at most 32)
// ending in tlast; unknown codes are accepted and dropped. Pen down reads and
// writes back the current bitmap row and then passes through the step state. A
// move goes through the step state per step with the pen up, and through the step
// then the mark state (row read, then row write) per step with the pen down, then
// the final step check and the status item; the grid edge limits the steps to
// GRID_SIZE - 1. Print reads one RAM row per cycle while the output is not stalled.
// The bitmap starts cleared after reset with no clearing pass, through a valid bit
// per row. After exit every command is accepted and dropped until reset. The next
// command is accepted while the last result still waits in the output register.
module turtle_grid_plotter #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: cmd[3:0], distance[9:4], zero fill.
  input  logic [tgp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: row_index[4:0], row_bits[36:5], pos_row[41:37],
  // pos_col[46:42], heading[48:47], pen_down[49], halted[50], zero fill.
  output logic [tgp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: kind.
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int unsigned CW     = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int unsigned N_ROWS = (GRID_SIZE < tgp_pkg::MAX_ROWS) ? GRID_SIZE
                                                                   : tgp_pkg::MAX_ROWS;
  localparam logic [CW-1:0] EDGE     = CW'(GRID_SIZE - 1);
  localparam logic [CW-1:0] LAST_ROW = CW'(N_ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MARK,
    S_STATUS,
    S_PRINT
  } state_t;

  state_t                     state;
  logic [CW-1:0]              cur_row;
  logic [CW-1:0]              cur_col;
  logic [1:0]                 facing;
  logic                       pen;
  logic                       stopped;
  logic [tgp_pkg::DIST_W-1:0] remain;
  logic [CW-1:0]              cnt;
  logic [GRID_SIZE-1:0]       row_valid;
  logic                       rd_vld;

  logic                        o_kind;
  logic                        o_last;
  logic [tgp_pkg::IDX_W-1:0]   o_row_index;
  logic [tgp_pkg::BITS_W-1:0]  o_row_bits;
  logic [tgp_pkg::IDX_W-1:0]   o_pos_row;
  logic [tgp_pkg::IDX_W-1:0]   o_pos_col;
  logic [1:0]                  o_heading;
  logic                        o_pen;
  logic                        o_halted;

  logic                        ram_we;
  logic [CW-1:0]               ram_waddr;
  logic [GRID_SIZE-1:0]        ram_wdata;
  logic                        ram_re;
  logic [CW-1:0]               ram_raddr;
  logic [GRID_SIZE-1:0]        ram_rdata;
  logic [GRID_SIZE-1:0]        row_old;

  logic                        accept;
  tgp_pkg::cmd_t               cmd;
  logic [tgp_pkg::DIST_W-1:0]  move_len;
  logic                        out_free;
  logic                        out_load;
  logic                        blocked;
  logic [CW-1:0]               next_row;
  logic [CW-1:0]               next_col;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = tgp_pkg::cmd_t'(s_axis_tdata[3:0]);
  assign move_len      = s_axis_tdata[9:4];
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && (state inside {S_STATUS, S_PRINT});
  assign row_old       = rd_vld ? ram_rdata : '0;

  always_comb begin
    blocked  = 1'b0;
    next_row = cur_row;
    next_col = cur_col;
    case (facing)
      tgp_pkg::HEAD_RIGHT: begin
        blocked  = (cur_col == EDGE);
        next_col = cur_col + CW'(1);
      end
      tgp_pkg::HEAD_DOWN: begin
        blocked  = (cur_row == EDGE);
        next_row = cur_row + CW'(1);
      end
      tgp_pkg::HEAD_LEFT: begin
        blocked  = (cur_col == '0);
        next_col = cur_col - CW'(1);
      end
      default: begin
        blocked  = (cur_row == '0);
        next_row = cur_row - CW'(1);
      end
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur_row;
    ram_we    = 1'b0;
    ram_waddr = cur_row;
    ram_wdata = row_old | (GRID_SIZE'(1) << cur_col);
    case (state)
      S_IDLE: begin
        if (accept && !stopped) begin
          if (cmd == tgp_pkg::CMD_PEN_DOWN) begin
            ram_re = 1'b1;
          end else if (cmd == tgp_pkg::CMD_PRINT) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
          end
        end
      end
      S_STEP: begin
        if (remain != '0 && !blocked && pen) begin
          ram_re    = 1'b1;
          ram_raddr = next_row;
        end
      end
      S_MARK: begin
        ram_we = 1'b1;
      end
      S_PRINT: begin
        if (out_free && cnt != LAST_ROW) begin
          ram_re    = 1'b1;
          ram_raddr = cnt + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cur_row       <= '0;
      cur_col       <= '0;
      facing        <= '0;
      pen           <= 1'b0;
      stopped       <= 1'b0;
      remain        <= '0;
      cnt           <= '0;
      row_valid     <= '0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (ram_re) begin
        rd_vld <= row_valid[ram_raddr];
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept && !stopped) begin
            case (cmd)
              tgp_pkg::CMD_PEN_UP: begin
                pen   <= 1'b0;
                state <= S_STATUS;
              end
              tgp_pkg::CMD_PEN_DOWN: begin
                pen    <= 1'b1;
                remain <= '0;
                state  <= S_MARK;
              end
              tgp_pkg::CMD_RIGHT: begin
                facing <= facing + 2'd1;
                state  <= S_STATUS;
              end
              tgp_pkg::CMD_LEFT: begin
                facing <= facing + 2'd3;
                state  <= S_STATUS;
              end
              tgp_pkg::CMD_MOVE: begin
                remain <= move_len;
                state  <= S_STEP;
              end
              tgp_pkg::CMD_PRINT: begin
                cnt   <= '0;
                state <= S_PRINT;
              end
              tgp_pkg::CMD_EXIT: begin
                stopped <= 1'b1;
                state   <= S_STATUS;
              end
              default: begin
              end
            endcase
          end
        end
        S_STEP: begin
          if (remain == '0 || blocked) begin
            state <= S_STATUS;
          end else begin
            cur_row <= next_row;
            cur_col <= next_col;
            remain  <= remain - tgp_pkg::DIST_W'(1);
            if (pen) begin
              state <= S_MARK;
            end
          end
        end
        S_MARK: begin
          state <= S_STEP;
        end
        S_STATUS: begin
          if (out_free) begin
            o_kind        <= tgp_pkg::KIND_STATUS;
            o_last        <= 1'b1;
            o_row_index   <= '0;
            o_row_bits    <= '0;
            o_pos_row     <= tgp_pkg::IDX_W'(cur_row);
            o_pos_col     <= tgp_pkg::IDX_W'(cur_col);
            o_heading     <= facing;
            o_pen         <= pen;
            o_halted      <= stopped;
            state         <= S_IDLE;
          end
        end
        S_PRINT: begin
          if (out_free) begin
            o_kind        <= tgp_pkg::KIND_ROW;
            o_last        <= (cnt == LAST_ROW);
            o_row_index   <= tgp_pkg::IDX_W'(cnt);
            o_row_bits    <= tgp_pkg::BITS_W'(row_old);
            o_pos_row     <= tgp_pkg::IDX_W'(cur_row);
            o_pos_col     <= tgp_pkg::IDX_W'(cur_col);
            o_heading     <= facing;
            o_pen         <= pen;
            o_halted      <= stopped;
            if (cnt == LAST_ROW) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {5'b0, o_halted, o_pen, o_heading, o_pos_col, o_pos_row,
                         o_row_bits, o_row_index};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  tgp_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hw/rtl/tgp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the bitmap of turtle_grid_plotter.
module tgp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/turtle_grid_plotter_tb.sv =====
// Self-checking testbench for turtle_grid_plotter: directed and random command items,
// with both stream sides idling at random, checked against a behavioral plotter model.
// Depends on tgp_pkg and the turtle_grid_plotter RTL.
module turtle_grid_plotter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] EDGE_CELL = 5'(tgp_pkg::MAX_ROWS - 1);

  typedef struct {
    logic        kind;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [4:0]  pos_row;
    logic [4:0]  pos_col;
    logic [1:0]  heading;
    logic        pen_down;
    logic        halted;
    logic        last;
  } plot_item_t;

  class plot_scoreboard;
    logic [31:0]       grid_rows[tgp_pkg::MAX_ROWS];
    logic [4:0]        row_q;
    logic [4:0]        col_q;
    tgp_pkg::heading_t facing;
    logic              pen_q;
    logic              halted_q;
    plot_item_t        expected[$];
    int                errors;

    function new();
      foreach (grid_rows[r]) grid_rows[r] = '0;
      row_q    = '0;
      col_q    = '0;
      facing   = tgp_pkg::HEAD_RIGHT;
      pen_q    = 1'b0;
      halted_q = 1'b0;
      errors   = 0;
    endfunction

    function void push_item(logic kind, logic [4:0] idx, logic [31:0] bits, logic last);
      plot_item_t it;
      it.kind      = kind;
      it.row_index = idx;
      it.row_bits  = bits;
      it.pos_row   = row_q;
      it.pos_col   = col_q;
      it.heading   = facing;
      it.pen_down  = pen_q;
      it.halted    = halted_q;
      it.last      = last;
      expected.push_back(it);
    endfunction

    function void note_command(logic [3:0] code, logic [5:0] steps);
      logic [1:0] h;
      logic       moved;
      if (halted_q) return;
      case (code)
        tgp_pkg::CMD_PEN_UP: pen_q = 1'b0;
        tgp_pkg::CMD_PEN_DOWN: begin
          pen_q = 1'b1;
          grid_rows[row_q][col_q] = 1'b1;
        end
        tgp_pkg::CMD_RIGHT: begin
          h = facing + 2'd1;
          facing = tgp_pkg::heading_t'(h);
        end
        tgp_pkg::CMD_LEFT: begin
          h = facing + 2'd3;
          facing = tgp_pkg::heading_t'(h);
        end
        tgp_pkg::CMD_MOVE: begin
          // Once the turtle reaches the edge it stays there, so the rest of the steps are no-ops.
          for (int i = 0; i < steps; i++) begin
            moved = 1'b1;
            case (facing)
              tgp_pkg::HEAD_RIGHT:
                if (col_q == EDGE_CELL) moved = 1'b0; else col_q = col_q + 5'd1;
              tgp_pkg::HEAD_DOWN:
                if (row_q == EDGE_CELL) moved = 1'b0; else row_q = row_q + 5'd1;
              tgp_pkg::HEAD_LEFT:
                if (col_q == '0) moved = 1'b0; else col_q = col_q - 5'd1;
              default:
                if (row_q == '0) moved = 1'b0; else row_q = row_q - 5'd1;
            endcase
            if (moved && pen_q) grid_rows[row_q][col_q] = 1'b1;
          end
        end
        tgp_pkg::CMD_PRINT: begin
          for (int r = 0; r < tgp_pkg::MAX_ROWS; r++)
            push_item(tgp_pkg::KIND_ROW, 5'(r), grid_rows[r], r == tgp_pkg::MAX_ROWS - 1);
          return;
        end
        tgp_pkg::CMD_EXIT: halted_q = 1'b1;
        default: return;
      endcase
      push_item(tgp_pkg::KIND_STATUS, '0, '0, 1'b1);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic kind, logic [tgp_pkg::OUT_DATA_W-1:0] data, logic last);
      plot_item_t e;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual kind %0b data %h last %0b",
                 $time, kind, data, last);
        return;
      end
      e = expected.pop_front();
      check_field("kind", e.kind, kind);
      check_field("row_index", e.row_index, data[4:0]);
      check_field("row_bits", e.row_bits, data[36:5]);
      check_field("pos_row", e.pos_row, data[41:37]);
      check_field("pos_col", e.pos_col, data[46:42]);
      check_field("heading", e.heading, data[48:47]);
      check_field("pen_down", e.pen_down, data[49]);
      check_field("halted", e.halted, data[50]);
      check_field("last", e.last, last);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [tgp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [tgp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;
  bit                             quiet = 1'b0;
  plot_scoreboard                 sb = new();

  turtle_grid_plotter dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  task automatic send_cmd(input logic [3:0] code, input logic [5:0] steps);
    while (!quiet && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, steps, code};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(code, steps);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
  endtask

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int         pick;
    logic [3:0] code;
    logic [5:0] steps;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(tgp_pkg::CMD_PEN_DOWN, 6'd63);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd0);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd63);
    send_cmd(tgp_pkg::CMD_RIGHT, 6'd0);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd63);
    send_cmd(tgp_pkg::CMD_RIGHT, 6'd21);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd5);
    send_cmd(tgp_pkg::CMD_PEN_UP, 6'd63);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd63);
    send_cmd(tgp_pkg::CMD_RIGHT, 6'd0);
    send_cmd(tgp_pkg::CMD_PEN_DOWN, 6'd42);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd1);
    send_cmd(tgp_pkg::CMD_LEFT, 6'd0);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd3);
    send_cmd(tgp_pkg::CMD_LEFT, 6'd63);
    send_cmd(tgp_pkg::CMD_LEFT, 6'd0);
    send_cmd(4'd0, 6'd63);
    send_cmd(4'd7, 6'd1);
    send_cmd(4'd8, 6'd0);
    send_cmd(4'd10, 6'd31);
    send_cmd(4'd15, 6'd63);
    send_cmd(tgp_pkg::CMD_PRINT, 6'd63);
    wait_drained();

    for (int i = 0; i < 350; i++) begin
      quiet = (i >= 140 && i < 220);
      pick  = $urandom_range(99);
      steps = 6'($urandom_range(63));
      if (pick < 45) begin
        code = tgp_pkg::CMD_MOVE;
        if ($urandom_range(99) < 50) steps = 6'($urandom_range(7));
        else if ($urandom_range(99) < 20) steps = 6'd63;
      end else if (pick < 55) code = tgp_pkg::CMD_RIGHT;
      else if (pick < 65) code = tgp_pkg::CMD_LEFT;
      else if (pick < 74) code = tgp_pkg::CMD_PEN_DOWN;
      else if (pick < 82) code = tgp_pkg::CMD_PEN_UP;
      else if (pick < 86) code = tgp_pkg::CMD_PRINT;
      else begin
        do code = 4'($urandom_range(15));
        while (code inside {tgp_pkg::CMD_PEN_UP, tgp_pkg::CMD_PEN_DOWN, tgp_pkg::CMD_RIGHT,
                            tgp_pkg::CMD_LEFT, tgp_pkg::CMD_MOVE, tgp_pkg::CMD_PRINT,
                            tgp_pkg::CMD_EXIT});
      end
      send_cmd(code, steps);
    end
    quiet = 1'b0;
    send_cmd(tgp_pkg::CMD_PRINT, 6'd0);
    wait_drained();

    send_cmd(tgp_pkg::CMD_EXIT, 6'd63);
    send_cmd(tgp_pkg::CMD_PRINT, 6'd0);
    send_cmd(tgp_pkg::CMD_MOVE, 6'd9);
    send_cmd(tgp_pkg::CMD_PEN_DOWN, 6'd0);
    send_cmd(tgp_pkg::CMD_RIGHT, 6'd0);
    send_cmd(4'd12, 6'd5);
    wait_drained();
    repeat (80) @(posedge clk);

    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/tgp_pkg.sv
hw/rtl/tgp_ram.sv
hw/rtl/turtle_grid_plotter.sv
tb/turtle_grid_plotter_tb.sv
